[rtl/fuzzy_brake_pressure_controller_unit_macros.svh]
// Assertion macros shared by the checker files of the brake pressure controller.
// Each macro expects a signal named clk, and all but FBPC_ASSERT_NEXT_ANY also rst_n, in the scope where it is used.
`ifndef FUZZY_BRAKE_PRESSURE_CONTROLLER_UNIT_MACROS_SVH
`define FUZZY_BRAKE_PRESSURE_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define FBPC_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fbpc_pkg.sv]
// Package of the fuzzy brake pressure controller: widths, constants and types.
// Used by every RTL module and interface file of the block; depends on nothing.
package fbpc_pkg;

  // Sweep of the centroid over evenly spaced output points.
  localparam int SWEEP_POINTS = 101;
  localparam int SPAN         = SWEEP_POINTS - 1;
  localparam int K_W          = $clog2(SWEEP_POINTS);

  // Sample format: 0..100 with 8 fraction bits.
  localparam int IN_W   = 15;
  localparam int IN_MAX = 25600;

  // Membership grades: full grade is 76800.
  localparam int GRADE_W    = 17;
  localparam int FULL_GRADE = 76800;

  // Accumulator and divider widths.
  localparam int MU_W   = GRADE_W + K_W;
  localparam int AREA_W = MU_W + K_W;
  localparam int MOM_W  = AREA_W + K_W;
  localparam int DEN_W  = AREA_W + K_W;
  localparam int NUM_W  = MOM_W + IN_W;
  localparam int Q_W    = IN_W;

  typedef logic [IN_W-1:0]    sample_t;
  typedef logic [GRADE_W-1:0] grade_t;
  typedef logic [MU_W-1:0]    mu_t;
  typedef logic [AREA_W-1:0]  area_t;
  typedef logic [MOM_W-1:0]   mom_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [DEN_W-1:0]   den_t;
  typedef logic [Q_W-1:0]     quot_t;

  // One slot of the sweep pipeline.
  typedef struct packed {
    logic  valid;
    mu_t   rise_lim;
    mu_t   fall_lim;
    area_t area;
    mom_t  mom;
  } sweep_t;

endpackage

[rtl/fbpc_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on fbpc_pkg for the field types.
interface fbpc_in_if import fbpc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t pedal_pressure;
  sample_t wheel_speed;
  sample_t car_speed;

  modport source (output valid, output pedal_pressure, output wheel_speed,
                  output car_speed, input ready);
  modport sink   (input valid, input pedal_pressure, input wheel_speed,
                  input car_speed, output ready);
endinterface

interface fbpc_out_if import fbpc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t brake_pressure;
  logic    no_rule_fired;

  modport source (output valid, output brake_pressure, output no_rule_fired,
                  input ready);
  modport sink   (input valid, input brake_pressure, input no_rule_fired,
                  output ready);
endinterface

[rtl/fbpc_member.sv]
// Membership grades and rule evaluation, three register stages.
// Depends on fbpc_pkg; feeds the clipped set limits into the sweep.
module fbpc_member import fbpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  sample_t pedal,
  input  sample_t wheel,
  input  sample_t car,
  output sweep_t  head
);

  logic    p_sat, w_sat, c_sat;
  sample_t p_s, w_s, c_s;
  logic [18:0] p6, w5, c5, dev, dev15;
  grade_t  p_low, p_med, p_high, w_slow, w_fast, c_fast;

  logic    va_r;
  grade_t  p_low_r, p_med_r, p_high_r, w_slow_r, w_fast_r, c_fast_r;
  logic    vb_r;
  grade_t  apply_r, release_r;
  grade_t  apply_nxt, release_nxt, fire_a, fire_r;
  logic [GRADE_W:0] apply_sum, release_sum;
  logic    vc_r;
  mu_t     rise_lim_r, fall_lim_r;

  // Saturate the samples and form the clamped ramps and triangle.
  always_comb begin
    p_sat = (pedal > sample_t'(IN_MAX));
    w_sat = (wheel > sample_t'(IN_MAX));
    c_sat = (car > sample_t'(IN_MAX));
    p_s   = p_sat ? sample_t'(IN_MAX) : pedal;
    w_s   = w_sat ? sample_t'(IN_MAX) : wheel;
    c_s   = c_sat ? sample_t'(IN_MAX) : car;
    p6    = 19'(p_s) * 19'd6;
    w5    = 19'(w_s) * 19'd5;
    c5    = 19'(c_s) * 19'd5;
    dev   = (p_s >= sample_t'(12800)) ? 19'(p_s) - 19'd12800 : 19'd12800 - 19'(p_s);
    dev15 = dev * 19'd15;
    p_low  = (p6 < 19'd76800) ? grade_t'(19'd76800 - p6) : '0;
    p_med  = (dev15 < 19'd76800) ? grade_t'(19'd76800 - dev15) : '0;
    p_high = (p6 > 19'd76800) ? grade_t'(p6 - 19'd76800) : '0;
    w_slow = (w5 < 19'd76800) ? grade_t'(19'd76800 - w5) : '0;
    w_fast = (w5 > 19'd51200) ? grade_t'(w5 - 19'd51200) : '0;
    c_fast = (c5 > 19'd51200) ? grade_t'(c5 - 19'd51200) : '0;
  end

  // Rule strengths: minimum for AND, sum per output set.
  always_comb begin
    fire_a      = (c_fast_r < w_fast_r) ? c_fast_r : w_fast_r;
    fire_a      = (p_high_r < fire_a) ? p_high_r : fire_a;
    fire_r      = (c_fast_r < w_slow_r) ? c_fast_r : w_slow_r;
    fire_r      = (p_high_r < fire_r) ? p_high_r : fire_r;
    apply_sum   = {1'b0, p_med_r} + {1'b0, fire_a};
    release_sum = {1'b0, p_low_r} + {1'b0, fire_r};
    apply_nxt   = apply_sum[GRADE_W-1:0];
    release_nxt = release_sum[GRADE_W-1:0];
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      p_low_r    <= p_low;
      p_med_r    <= p_med;
      p_high_r   <= p_high;
      w_slow_r   <= w_slow;
      w_fast_r   <= w_fast;
      c_fast_r   <= c_fast;
      apply_r    <= apply_nxt;
      release_r  <= release_nxt;
      rise_lim_r <= mu_t'(apply_r) * mu_t'(SPAN);
      fall_lim_r <= mu_t'(release_r) * mu_t'(SPAN);
    end
  end

  assign head = '{valid: vc_r, rise_lim: rise_lim_r, fall_lim: fall_lim_r,
                  area: '0, mom: '0};

endmodule

[rtl/fbpc_sweep.sv]
// Centroid sweep: one register stage per output point accumulates area and moment.
// Depends on fbpc_pkg.
module fbpc_sweep import fbpc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  sweep_t head,
  output sweep_t tail
);

  sweep_t slot [0:SWEEP_POINTS];

  assign slot[0] = head;

  for (genvar k = 0; k <= SPAN; k++) begin : g_pt
    localparam mu_t RISE_C = mu_t'(FULL_GRADE * k);
    localparam mu_t FALL_C = mu_t'(FULL_GRADE * (SPAN - k));
    mu_t rise, fall, mu;
    logic [MU_W+K_W-1:0] prod;
    logic   v_r;
    area_t  area_r;
    mom_t   mom_r;
    mu_t    rl_r, fl_r;

    // Aggregate grade at this point: max of the two clipped ramps.
    always_comb begin
      rise = (RISE_C < slot[k].rise_lim) ? RISE_C : slot[k].rise_lim;
      fall = (slot[k].fall_lim < FALL_C) ? slot[k].fall_lim : FALL_C;
      mu   = (rise > fall) ? rise : fall;
      prod = (MU_W+K_W)'(mu) * (MU_W+K_W)'(k);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= slot[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rl_r   <= slot[k].rise_lim;
        fl_r   <= slot[k].fall_lim;
        area_r <= slot[k].area + area_t'(mu);
        mom_r  <= slot[k].mom + mom_t'(prod);
      end
    end

    assign slot[k+1] = '{valid: v_r, rise_lim: rl_r, fall_lim: fl_r,
                         area: area_r, mom: mom_r};
  end

  assign tail = slot[SWEEP_POINTS];

endmodule

[rtl/fbpc_div.sv]
// Centroid division: scaling stage, then one restoring quotient bit per stage.
// Depends on fbpc_pkg.
module fbpc_div import fbpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  sweep_t  tail,
  output logic    res_valid,
  output sample_t res_brake,
  output logic    res_none
);

  logic [MOM_W+4:0] mom25;
  logic  v_r    [0:Q_W];
  logic  zero_r [0:Q_W];
  num_t  rem_r  [0:Q_W];
  den_t  den_r  [0:Q_W];
  quot_t q_r    [0:Q_W];

  // Numerator is moment * 25600, denominator is area * span.
  assign mom25 = ((MOM_W+5)'(tail.mom) << 4) + ((MOM_W+5)'(tail.mom) << 3)
               + (MOM_W+5)'(tail.mom);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (tail.area == '0);
      rem_r[0]  <= {mom25, 10'b0};
      den_r[0]  <= den_t'(tail.area) * den_t'(SPAN);
      q_r[0]    <= '0;
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    localparam int B = Q_W - 1 - j;
    num_t shifted;
    logic ge;

    always_comb begin
      shifted = num_t'(den_r[j]) << B;
      ge      = (rem_r[j] >= shifted);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[j+1] <= zero_r[j];
        den_r[j+1]  <= den_r[j];
        rem_r[j+1]  <= ge ? rem_r[j] - shifted : rem_r[j];
        q_r[j+1]    <= q_r[j] | (quot_t'(ge) << B);
      end
    end
  end

  // Zero area gives a zero result with the flag set.
  always_comb begin
    res_valid = v_r[Q_W];
    res_none  = zero_r[Q_W];
    if (zero_r[Q_W]) begin
      res_brake = '0;
    end else if (q_r[Q_W] > quot_t'(IN_MAX)) begin
      res_brake = sample_t'(IN_MAX);
    end else begin
      res_brake = q_r[Q_W];
    end
  end

endmodule

[rtl/fuzzy_brake_pressure_controller_unit.sv]
// Fuzzy brake pressure controller, top level.
// Instantiates the membership, sweep and division stages; depends on fbpc_pkg, fbpc_if.
//
// Usage: samples of pedal pressure, wheel speed and car speed (0..100, 8 fraction
// bits) arrive on in_ch; each accepted transaction yields exactly one result on
// out_ch with the centroid brake pressure and a flag set when no rule fires.
// Inputs above 100 are saturated to 100.
// From acceptance to out_ch.valid a transaction passes three membership/rule
// stages, one stage per sweep point, one scaling stage and fifteen quotient-bit
// stages of the divider.
// Throughput: one transaction per cycle while out_ch does not stall; the per-point
// sweep stages and the one-bit-per-stage divider are fully pipelined.
// Reset (rst_n low, synchronous) clears every stage valid bit; results in flight
// are dropped and out_ch.valid is low after the reset edge.
// When the receiver holds out_ch.ready low with a result waiting, the whole
// pipeline holds and in_ch.ready drops; nothing is lost or repeated, and empty
// slots move on while out_ch.valid is low.
module fuzzy_brake_pressure_controller_unit import fbpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fbpc_in_if.sink     in_ch,
  fbpc_out_if.source  out_ch
);

  logic    en;
  sweep_t  head, tail;
  logic    res_valid, res_none;
  sample_t res_brake;

  // The pipeline advances unless a finished result is being held.
  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;

  fbpc_member u_member (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .pedal    (in_ch.pedal_pressure),
    .wheel    (in_ch.wheel_speed),
    .car      (in_ch.car_speed),
    .head     (head)
  );

  fbpc_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .head  (head),
    .tail  (tail)
  );

  fbpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tail      (tail),
    .res_valid (res_valid),
    .res_brake (res_brake),
    .res_none  (res_none)
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.brake_pressure = res_brake;
  assign out_ch.no_rule_fired  = res_none;

endmodule

[rtl/fbpc_checker.sv]
// Port-level checks of the brake pressure controller, bound to the top level.
// Depends on fbpc_pkg and the assertion macro header.
`include "fuzzy_brake_pressure_controller_unit_macros.svh"

module fbpc_checker import fbpc_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t brake,
  input logic    none
);

  // A held result stays offered with the same payload.
  `FBPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FBPC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(brake) && $stable(none), "result changed while stalled")

  // A result with no fired rule carries zero pressure.
  `FBPC_ASSERT_SAME(a_none_zero, out_valid && none, brake == '0, "flagged result not zero")

  // The centroid never leaves the output range.
  `FBPC_ASSERT_SAME(a_range, out_valid, brake <= sample_t'(IN_MAX), "brake pressure out of range")

  // Reset empties the pipeline.
  `FBPC_ASSERT_NEXT_ANY(a_reset, !rst_n, !out_valid, "result valid after reset")

endmodule

bind fuzzy_brake_pressure_controller_unit fbpc_checker u_fbpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .brake     (out_ch.brake_pressure),
  .none      (out_ch.no_rule_fired)
);
